// ----- hdl/imc_pkg.sv -----
// Shared types, codes and helpers for the input event motion coalescer.
`default_nettype none
package imc_pkg;

    localparam int unsigned TOUCH_GAIN = 700;
    localparam int unsigned MUL_STEPS  = 16;
    localparam int unsigned DIV_STEPS  = 33;

    localparam logic [4:0] FUNC_SYNC = 5'd0;
    localparam logic [4:0] FUNC_KEY  = 5'd1;
    localparam logic [4:0] FUNC_REL  = 5'd2;
    localparam logic [4:0] FUNC_ABS  = 5'd3;

    localparam logic [1:0] KIND_MOTION = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ABS  = 2'd1;
    localparam logic [1:0] PEND_REL  = 2'd2;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MAX_X  = 3'd1;
    localparam logic [2:0] REG_MIN_Y  = 3'd2;
    localparam logic [2:0] REG_MAX_Y  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_ORIGIN = 3'd6;
    localparam logic [2:0] REG_TPAD   = 3'd7;

    localparam logic [9:0] CODE_TOOL_LO = 10'h140;
    localparam logic [9:0] CODE_TOOL_HI = 10'h147;
    localparam logic [9:0] CODE_TOUCH   = 10'h14A;
    localparam logic [9:0] CODE_BTN_LO  = 10'h110;
    localparam logic [9:0] CODE_BTN_HI  = 10'h117;
    localparam logic [9:0] CODE_LEFT    = 10'h110;

    localparam logic signed [15:0] VAL_REPEAT = 16'sd2;

    localparam logic signed [34:0] SAT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_MIN = 35'sh7_8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_CALC,
        ST_FLUSH,
        ST_KEY
    } state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV,
        M_DONE
    } mstate_t;

    typedef struct packed {
        logic               start;
        logic signed [17:0] a;
        logic [15:0]        b;
        logic signed [16:0] den;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] q;
    } md_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[31:0];
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/imc_muldiv.sv -----
// Serial multiply then divide: trunc(a*b/den), zero when den is zero.
`default_nettype none
module imc_muldiv
    import imc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire md_req_t req,
    output md_rsp_t      rsp
);

    mstate_t      state_reg, state_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         neg_reg, neg_next;
    logic         zero_reg, zero_next;
    logic [32:0]  mcand_reg, mcand_next;
    logic [15:0]  mult_reg, mult_next;
    logic [32:0]  num_reg, num_next;
    logic [16:0]  dmag_reg, dmag_next;
    logic [16:0]  rem_reg, rem_next;
    logic [17:0]  trial;
    logic [17:0]  amag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        num_reg   <= num_next;
        dmag_reg  <= dmag_next;
        rem_reg   <= rem_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: if (req.start) state_next = M_MUL;
            M_MUL:  if (cnt_reg == 6'(MUL_STEPS - 1)) state_next = M_DIV;
            M_DIV:  if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = M_DONE;
            M_DONE: state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    assign amag  = req.a[17] ? 18'(-req.a) : 18'(req.a);
    assign trial = {rem_reg, num_reg[32]} - {1'b0, dmag_reg};

    always_comb begin
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        num_next   = num_reg;
        dmag_next  = dmag_reg;
        rem_next   = rem_reg;
        rsp.done   = 1'b0;
        rsp.q      = '0;
        unique case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    cnt_next   = '0;
                    neg_next   = req.a[17] ^ req.den[16];
                    zero_next  = (req.den == '0);
                    mcand_next = 33'(amag);
                    mult_next  = req.b;
                    num_next   = '0;
                    dmag_next  = req.den[16] ? 17'(-req.den) : 17'(req.den);
                end
            end
            M_MUL: begin
                if (mult_reg[0]) num_next = num_reg + mcand_reg;
                mcand_next = {mcand_reg[31:0], 1'b0};
                mult_next  = {1'b0, mult_reg[15:1]};
                rem_next   = '0;
                cnt_next   = (cnt_reg == 6'(MUL_STEPS - 1)) ? '0 : cnt_reg + 6'd1;
            end
            M_DIV: begin
                if (!trial[17]) begin
                    rem_next = trial[16:0];
                    num_next = {num_reg[31:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[15:0], num_reg[32]};
                    num_next = {num_reg[31:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
            end
            M_DONE: begin
                rsp.done = 1'b1;
                if (zero_reg) begin
                    rsp.q = '0;
                end else if (neg_reg) begin
                    rsp.q = -$signed({1'b0, num_reg});
                end else begin
                    rsp.q = $signed({1'b0, num_reg});
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/input_event_motion_coalescer_top.sv -----
// Top level of the input event motion coalescer.
// Flow: an accepted event is processed; a key result may follow a flush of pending motion,
// and absolute motion first runs the serial multiply and then the serial divide.
// Handshake: one transaction at a time, s_ready is high only in idle; the serial
// multiply and divide and output stalls hold the flow until they are done.
// Reset: synchronous active-low; registers take their defaults, nothing pending.
`default_nettype none
module input_event_motion_coalescer_top
    import imc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [4:0]         s_func,
    input  wire logic [9:0]         s_event_code,
    input  wire logic signed [15:0] s_event_value,
    input  wire logic [31:0]        s_time_ms,
    input  wire logic signed [15:0] s_pointer_x,
    input  wire logic signed [15:0] s_pointer_y,
    input  wire logic               s_batch_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_kind,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic [9:0]              m_key_code,
    output logic                    m_key_state,
    output logic [31:0]             m_stamp_ms,
    output logic                    m_last
);

    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [13:0]        width_reg, height_reg;
    logic [31:0]        origin_reg;
    logic               tpad_reg;

    state_t state_reg, state_next;

    logic [4:0]         func_reg;
    logic [9:0]         code_reg;
    logic signed [15:0] val_reg;
    logic [31:0]        time_reg;
    logic signed [15:0] px_reg, py_reg;
    logic               bend_reg;

    logic signed [31:0] abs_x_reg, abs_x_next, abs_y_reg, abs_y_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [1:0]         pend_reg, pend_next;
    logic signed [16:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic               skip_x_reg, skip_x_next, skip_y_reg, skip_y_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [31:0] posx_reg, posx_next, posy_reg, posy_next;
    logic [9:0]         kcode_reg, kcode_next;
    logic               kstate_reg, kstate_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic               last_reg, last_next;

    md_req_t req;
    md_rsp_t rsp;

    logic               accept, out_free, load;
    logic               is_axis, motion, is_rel, is_abs, is_key, is_tool, key_emit;
    logic               ysel;
    logic signed [15:0] mn, mx;
    logic signed [16:0] raw, den, prev_sel;
    logic signed [17:0] diff;
    logic               skip_sel;
    logic signed [15:0] org;

    imc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg  <= 16'sd0;
            max_x_reg  <= 16'sd4095;
            min_y_reg  <= 16'sd0;
            max_y_reg  <= 16'sd4095;
            width_reg  <= 14'd1024;
            height_reg <= 14'd768;
            origin_reg <= '0;
            tpad_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MIN_X:  min_x_reg  <= cfg_wdata[15:0];
                REG_MAX_X:  max_x_reg  <= cfg_wdata[15:0];
                REG_MIN_Y:  min_y_reg  <= cfg_wdata[15:0];
                REG_MAX_Y:  max_y_reg  <= cfg_wdata[15:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[13:0];
                REG_HEIGHT: height_reg <= cfg_wdata[13:0];
                REG_ORIGIN: origin_reg <= cfg_wdata;
                REG_TPAD:   tpad_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            abs_x_reg   <= '0;
            abs_y_reg   <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            pend_reg    <= PEND_NONE;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            skip_x_reg  <= 1'b0;
            skip_y_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            abs_x_reg   <= abs_x_next;
            abs_y_reg   <= abs_y_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            pend_reg    <= pend_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            skip_x_reg  <= skip_x_next;
            skip_y_reg  <= skip_y_next;
        end
        if (accept) begin
            func_reg <= s_func;
            code_reg <= s_event_code;
            val_reg  <= s_event_value;
            time_reg <= s_time_ms;
            px_reg   <= s_pointer_x;
            py_reg   <= s_pointer_y;
            bend_reg <= s_batch_end;
        end
        kind_reg   <= kind_next;
        posx_reg   <= posx_next;
        posy_reg   <= posy_next;
        kcode_reg  <= kcode_next;
        kstate_reg <= kstate_next;
        stamp_reg  <= stamp_next;
        last_reg   <= last_next;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign is_axis  = (code_reg <= 10'd1);
    assign is_rel   = (func_reg == FUNC_REL) && is_axis;
    assign is_abs   = (func_reg == FUNC_ABS) && is_axis;
    assign motion   = is_rel || is_abs;
    assign is_key   = (func_reg == FUNC_KEY) && (val_reg != VAL_REPEAT);
    assign is_tool  = (code_reg >= CODE_TOOL_LO) && (code_reg <= CODE_TOOL_HI);
    assign key_emit = is_key && !is_tool;

    assign ysel     = code_reg[0];
    assign mn       = ysel ? min_y_reg : min_x_reg;
    assign mx       = ysel ? max_y_reg : max_x_reg;
    assign raw      = 17'(val_reg) - 17'(mn);
    assign den      = 17'(mx) - 17'(mn);
    assign prev_sel = ysel ? prev_y_reg : prev_x_reg;
    assign diff     = 18'(raw) - 18'(prev_sel);
    assign skip_sel = ysel ? skip_y_reg : skip_x_reg;
    assign org      = ysel ? origin_reg[31:16] : origin_reg[15:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_PROC;
            ST_PROC: begin
                if (is_abs && !(tpad_reg && skip_sel)) begin
                    state_next = ST_CALC;
                end else if (motion) begin
                    state_next = bend_reg ? ST_FLUSH : ST_IDLE;
                end else if (pend_reg != PEND_NONE) begin
                    state_next = ST_FLUSH;
                end else if (key_emit) begin
                    state_next = ST_KEY;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALC: if (rsp.done) state_next = bend_reg ? ST_FLUSH : ST_IDLE;
            ST_FLUSH: begin
                if (out_free) state_next = (!motion && key_emit) ? ST_KEY : ST_IDLE;
            end
            ST_KEY: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        abs_x_next  = abs_x_reg;
        abs_y_next  = abs_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        pend_next   = pend_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        skip_x_next = skip_x_reg;
        skip_y_next = skip_y_reg;
        load        = 1'b0;
        kind_next   = kind_reg;
        posx_next   = posx_reg;
        posy_next   = posy_reg;
        kcode_next  = kcode_reg;
        kstate_next = kstate_reg;
        stamp_next  = stamp_reg;
        last_next   = last_reg;
        req.start   = 1'b0;
        req.a       = tpad_reg ? diff : 18'(raw);
        req.b       = tpad_reg ? 16'(TOUCH_GAIN) : {2'b00, (ysel ? height_reg : width_reg)};
        req.den     = den;
        unique case (state_reg)
            ST_IDLE: ;
            ST_PROC: begin
                if (is_rel) begin
                    if (ysel) dy_next = sat32(35'(dy_reg) + 35'(val_reg));
                    else      dx_next = sat32(35'(dx_reg) + 35'(val_reg));
                    pend_next = PEND_REL;
                end else if (is_abs) begin
                    if (tpad_reg && skip_sel) begin
                        if (ysel) begin
                            skip_y_next = 1'b0;
                            prev_y_next = raw;
                        end else begin
                            skip_x_next = 1'b0;
                            prev_x_next = raw;
                        end
                        pend_next = PEND_REL;
                    end else begin
                        req.start = 1'b1;
                    end
                end else if (is_key && is_tool && tpad_reg) begin
                    skip_x_next = 1'b1;
                    skip_y_next = 1'b1;
                end
            end
            ST_CALC: begin
                if (rsp.done) begin
                    if (tpad_reg) begin
                        if (ysel) begin
                            dy_next     = sat32(35'(rsp.q));
                            prev_y_next = raw;
                        end else begin
                            dx_next     = sat32(35'(rsp.q));
                            prev_x_next = raw;
                        end
                        pend_next = PEND_REL;
                    end else begin
                        if (ysel) abs_y_next = sat32(35'(rsp.q) + 35'(org));
                        else      abs_x_next = sat32(35'(rsp.q) + 35'(org));
                        pend_next = PEND_ABS;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    load        = 1'b1;
                    kind_next   = KIND_MOTION;
                    kcode_next  = '0;
                    kstate_next = 1'b0;
                    stamp_next  = time_reg;
                    last_next   = motion || !key_emit;
                    if (pend_reg == PEND_REL) begin
                        posx_next = sat32(35'(px_reg) + 35'(dx_reg));
                        posy_next = sat32(35'(py_reg) + 35'(dy_reg));
                    end else begin
                        posx_next = abs_x_reg;
                        posy_next = abs_y_reg;
                    end
                    abs_x_next = '0;
                    abs_y_next = '0;
                    dx_next    = '0;
                    dy_next    = '0;
                    pend_next  = PEND_NONE;
                end
            end
            ST_KEY: begin
                if (out_free) begin
                    load        = 1'b1;
                    posx_next   = '0;
                    posy_next   = '0;
                    kstate_next = (val_reg != 16'sd0);
                    stamp_next  = time_reg;
                    last_next   = 1'b1;
                    if (code_reg == CODE_TOUCH) begin
                        kind_next  = KIND_BUTTON;
                        kcode_next = CODE_LEFT;
                    end else if (code_reg >= CODE_BTN_LO && code_reg <= CODE_BTN_HI) begin
                        kind_next  = KIND_BUTTON;
                        kcode_next = code_reg;
                    end else begin
                        kind_next  = KIND_KEY;
                        kcode_next = code_reg;
                    end
                end
            end
            default: ;
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_pos_x     = posx_reg;
    assign m_pos_y     = posy_reg;
    assign m_key_code  = kcode_reg;
    assign m_key_state = kstate_reg;
    assign m_stamp_ms  = stamp_reg;
    assign m_last      = last_reg;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the input event motion coalescer top level.
`default_nettype none
module testbench;
    import imc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [2:0] cfg_addr;
    logic [31:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [4:0] s_func;
    logic [9:0] s_event_code;
    logic signed [15:0] s_event_value;
    logic [31:0] s_time_ms;
    logic signed [15:0] s_pointer_x;
    logic signed [15:0] s_pointer_y;
    logic s_batch_end;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_kind;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic [9:0] m_key_code;
    logic m_key_state;
    logic [31:0] m_stamp_ms;
    logic m_last;

    input_event_motion_coalescer_top u_top (.*);

    typedef struct {
        logic [1:0] kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [9:0] key_code;
        logic key_state;
        logic [31:0] stamp_ms;
        logic last;
    } report_t;

    report_t pending_reports[$];
    int errors;
    bit quiet_in;
    bit quiet_out;
    int stall_pct;
    int idle_cycles;

    // predictor state
    longint min_x, max_x, min_y, max_y, scr_w, scr_h, org_x, org_y;
    bit tpad;
    longint abs_x, abs_y, dlt_x, dlt_y, prv_x, prv_y;
    logic [1:0] pend;
    bit skip_x, skip_y;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint quot(input longint n, input longint d);
        if (d == 0) return 0;
        return n / d;
    endfunction

    function automatic void push_report(input logic [1:0] k, input longint px,
                                        input longint py, input logic [9:0] c,
                                        input logic st, input logic [31:0] t);
        report_t r;
        r.kind = k;
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.key_code = c;
        r.key_state = st;
        r.stamp_ms = t;
        r.last = 1'b0;
        pending_reports.push_back(r);
    endfunction

    function automatic int flush_motion(input longint px, input longint py,
                                        input logic [31:0] t);
        int n;
        n = 0;
        if (pend == PEND_REL) begin
            push_report(KIND_MOTION, clamp32(px + dlt_x), clamp32(py + dlt_y), '0, 1'b0, t);
            n = 1;
        end else if (pend == PEND_ABS) begin
            push_report(KIND_MOTION, abs_x, abs_y, '0, 1'b0, t);
            n = 1;
        end
        abs_x = 0; abs_y = 0; dlt_x = 0; dlt_y = 0;
        pend = PEND_NONE;
        return n;
    endfunction

    function automatic void predict_event(input logic [4:0] f, input logic [9:0] c,
                                          input logic signed [15:0] v,
                                          input logic [31:0] t,
                                          input logic signed [15:0] px,
                                          input logic signed [15:0] py,
                                          input logic be);
        bit axis, motion;
        int n;
        longint val, raw;
        logic st;
        axis = c <= 10'd1;
        motion = (f == FUNC_REL || f == FUNC_ABS) && axis;
        val = v;
        n = 0;
        if (!motion) n += flush_motion(px, py, t);
        if (f == FUNC_REL && axis) begin
            if (c == 0) dlt_x = clamp32(dlt_x + val);
            else dlt_y = clamp32(dlt_y + val);
            pend = PEND_REL;
        end else if (f == FUNC_ABS && axis) begin
            if (tpad) begin
                if (c == 0) begin
                    raw = val - min_x;
                    if (skip_x) skip_x = 0;
                    else dlt_x = clamp32(quot((raw - prv_x) * TOUCH_GAIN, max_x - min_x));
                    prv_x = raw;
                end else begin
                    raw = val - min_y;
                    if (skip_y) skip_y = 0;
                    else dlt_y = clamp32(quot((raw - prv_y) * TOUCH_GAIN, max_y - min_y));
                    prv_y = raw;
                end
                pend = PEND_REL;
            end else begin
                if (c == 0)
                    abs_x = clamp32(quot((val - min_x) * scr_w, max_x - min_x) + org_x);
                else
                    abs_y = clamp32(quot((val - min_y) * scr_h, max_y - min_y) + org_y);
                pend = PEND_ABS;
            end
        end else if (f == FUNC_KEY && v != VAL_REPEAT) begin
            st = (v != 0);
            if (c >= CODE_TOOL_LO && c <= CODE_TOOL_HI) begin
                if (tpad) begin
                    skip_x = 1; skip_y = 1;
                end
            end else if (c == CODE_TOUCH) begin
                push_report(KIND_BUTTON, 0, 0, CODE_LEFT, st, t); n++;
            end else if (c >= CODE_BTN_LO && c <= CODE_BTN_HI) begin
                push_report(KIND_BUTTON, 0, 0, c, st, t); n++;
            end else begin
                push_report(KIND_KEY, 0, 0, c, st, t); n++;
            end
        end
        if (be) n += flush_motion(px, py, t);
        if (n > 0) pending_reports[$].last = 1'b1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_X: min_x = $signed(d[15:0]);
            REG_MAX_X: max_x = $signed(d[15:0]);
            REG_MIN_Y: min_y = $signed(d[15:0]);
            REG_MAX_Y: max_y = $signed(d[15:0]);
            REG_WIDTH: scr_w = d[13:0];
            REG_HEIGHT: scr_h = d[13:0];
            REG_ORIGIN: begin
                org_x = $signed(d[15:0]);
                org_y = $signed(d[31:16]);
            end
            default: tpad = d[0];
        endcase
    endtask

    task automatic send_event(input logic [4:0] f, input logic [9:0] c,
                              input logic signed [15:0] v, input logic [31:0] t,
                              input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic be);
        while (!quiet_in && $urandom_range(99) < stall_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_event_code <= c;
        s_event_value <= v;
        s_time_ms <= t;
        s_pointer_x <= px;
        s_pointer_y <= py;
        s_batch_end <= be;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_event(f, c, v, t, px, py, be);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic rand_event(input bit well_formed);
        logic [4:0] f;
        logic [9:0] c;
        int pick;
        pick = $urandom_range(99);
        f = 5'($urandom);
        c = 10'($urandom_range(767));
        if (well_formed) begin
            if (pick < 35) begin
                f = FUNC_ABS; c = 10'($urandom_range(1));
            end else if (pick < 60) begin
                f = FUNC_REL; c = 10'($urandom_range(1));
            end else if (pick < 85) begin
                f = FUNC_KEY;
                case ($urandom_range(3))
                    0: c = 10'(CODE_TOOL_LO + $urandom_range(7));
                    1: c = CODE_TOUCH;
                    2: c = 10'(CODE_BTN_LO + $urandom_range(7));
                    default: c = 10'($urandom_range(767));
                endcase
            end else begin
                f = FUNC_SYNC;
            end
        end
        send_event(f, c,
                   16'((f == FUNC_KEY && $urandom_range(1)) ? $urandom_range(2) : $urandom),
                   $urandom, 16'($urandom), 16'($urandom), $urandom_range(3) == 0);
    endtask

    task automatic test_directed_keys();
        send_event(FUNC_KEY, 10'd30, 16'sd1, 32'd0, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, 10'd30, VAL_REPEAT, 32'd1, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, 10'd30, -16'sd32768, 32'hFFFFFFFF, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, 10'd30, 16'sd0, 32'd3, 16'sd0, 16'sd0, 1'b1);
        send_event(FUNC_KEY, CODE_TOUCH, 16'sd1, 32'd4, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, CODE_BTN_HI, 16'sd0, 32'd5, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, 10'd767, 16'sd1, 32'd6, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, CODE_TOOL_LO, 16'sd1, 32'd7, 16'sd0, 16'sd0, 1'b0);
        send_event(5'd31, 10'd767, 16'sd0, 32'd8, 16'sd0, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_directed_motion();
        send_event(FUNC_REL, 10'd0, 16'sd32767, 32'd10, 16'sd32767, -16'sd32768, 1'b0);
        send_event(FUNC_REL, 10'd1, -16'sd32768, 32'd11, 16'sd32767, -16'sd32768, 1'b0);
        send_event(FUNC_REL, 10'd2, 16'sd5, 32'd12, 16'sd1, 16'sd1, 1'b0);
        send_event(FUNC_ABS, 10'd0, 16'sd4095, 32'd13, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_ABS, 10'd1, -16'sd32768, 32'd14, 16'sd0, 16'sd0, 1'b1);
        send_event(FUNC_SYNC, 10'd0, 16'sd0, 32'd15, 16'sd0, 16'sd0, 1'b1);
        drain();
        write_reg(REG_MAX_X, 32'd0);
        write_reg(REG_ORIGIN, 32'h7FFF_8000);
        send_event(FUNC_ABS, 10'd0, 16'sd100, 32'd16, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_ABS, 10'd1, 16'sd32767, 32'd17, 16'sd0, 16'sd0, 1'b1);
        drain();
        write_reg(REG_TPAD, 32'd1);
        send_event(FUNC_ABS, 10'd1, 16'sd32767, 32'd18, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_KEY, CODE_TOOL_HI, 16'sd1, 32'd19, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_ABS, 10'd1, -16'sd32768, 32'd20, 16'sd0, 16'sd0, 1'b0);
        send_event(FUNC_ABS, 10'd0, 16'sd500, 32'd21, 16'sd0, 16'sd0, 1'b1);
        drain();
    endtask

    task automatic test_random_config(input int items);
        write_reg(REG_MIN_X, $urandom);
        write_reg(REG_MAX_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(8191));
        write_reg(REG_MIN_Y, $urandom_range(1) ? $urandom : 32'hFFFF_8000);
        write_reg(REG_MAX_Y, $urandom_range(1) ? $urandom : 32'h0000_7FFF);
        write_reg(REG_WIDTH, $urandom_range(1) ? 32'd8192 : $urandom_range(1, 8192));
        write_reg(REG_HEIGHT, $urandom_range(1) ? 32'd1 : $urandom_range(1, 8192));
        write_reg(REG_ORIGIN, $urandom);
        write_reg(REG_TPAD, $urandom_range(1));
        for (int i = 0; i < items; i++) begin
            rand_event($urandom_range(9) != 0);
        end
        drain();
    endtask

    task automatic test_no_stall();
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        test_random_config(100);
        quiet_in = 1'b0;
        quiet_out = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= stall_pct);
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result kind %0d", m_kind);
                    errors++;
                end else begin
                    report_t e;
                    e = pending_reports.pop_front();
                    if (m_kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, m_kind); errors++;
                    end
                    if (m_pos_x !== e.pos_x) begin
                        $error("pos_x exp %0d got %0d", e.pos_x, m_pos_x); errors++;
                    end
                    if (m_pos_y !== e.pos_y) begin
                        $error("pos_y exp %0d got %0d", e.pos_y, m_pos_y); errors++;
                    end
                    if (m_key_code !== e.key_code) begin
                        $error("key_code exp %0h got %0h", e.key_code, m_key_code); errors++;
                    end
                    if (m_key_state !== e.key_state) begin
                        $error("key_state exp %0d got %0d", e.key_state, m_key_state);
                        errors++;
                    end
                    if (m_stamp_ms !== e.stamp_ms) begin
                        $error("stamp_ms exp %0h got %0h", e.stamp_ms, m_stamp_ms); errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_last); errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        errors = 0; idle_cycles = 0; stall_pct = 14;
        quiet_in = 1'b0; quiet_out = 1'b0;
        min_x = 0; max_x = 4095; min_y = 0; max_y = 4095;
        scr_w = 1024; scr_h = 768; org_x = 0; org_y = 0; tpad = 0;
        abs_x = 0; abs_y = 0; dlt_x = 0; dlt_y = 0; prv_x = 0; prv_y = 0;
        pend = PEND_NONE; skip_x = 0; skip_y = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_func = '0; s_event_code = '0; s_event_value = '0;
        s_time_ms = '0; s_pointer_x = '0; s_pointer_y = '0; s_batch_end = 1'b0;
        m_ready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_keys();
        test_directed_motion();
        test_no_stall();
        for (int p = 0; p < 9; p++) begin
            test_random_config(100);
        end
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/imc_pkg.sv
hdl/imc_muldiv.sv
hdl/input_event_motion_coalescer_top.sv
bench/testbench.sv
